// ----- rtl/modem_bus_master_register_block_unit_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef MODEM_BUS_MASTER_REGISTER_BLOCK_UNIT_MACROS_SVH
`define MODEM_BUS_MASTER_REGISTER_BLOCK_UNIT_MACROS_SVH

// Same-cycle implication.
`define MBMR_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("mbmr assertion failed");

// Next-cycle implication.
`define MBMR_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("mbmr assertion failed");

`endif

// ----- rtl/mbmr_pkg.sv -----
`timescale 1ns / 1ps

package mbmr_pkg;

	localparam int ChannelCount = 2;
	localparam int IndexBits    = 5;

	typedef logic [IndexBits-1:0] idx_t;

	localparam logic ModeRead  = 1'b0;
	localparam logic ModeWrite = 1'b1;

	localparam logic [1:0] SizeByte = 2'd0;
	localparam logic [1:0] SizeHalf = 2'd1;
	localparam logic [1:0] SizeWord = 2'd2;

	// channel register offsets
	localparam logic [3:0] OffBase = 4'h0;
	localparam logic [3:0] OffCiv  = 4'h4;
	localparam logic [3:0] OffLvi  = 4'h5;
	localparam logic [3:0] OffSts  = 4'h6;
	localparam logic [3:0] OffPicb = 4'h8;
	localparam logic [3:0] OffPiv  = 4'ha;
	localparam logic [3:0] OffCtl  = 4'hb;

	localparam logic [6:0] AddrGlobCtl = 7'h3c;
	localparam logic [6:0] AddrGlobSts = 7'h40;
	localparam logic [6:0] AddrSem     = 7'h44;

	localparam int StHalt = 0;
	localparam logic [4:0] StClrMask = 5'h1c;
	localparam logic [4:0] StReset   = 5'h01;
	localparam int CtRun = 0;
	localparam int CtRst = 1;
	localparam logic [4:0] CtIrqEn = 5'h1c;

	localparam int GcColdRst = 1;
	localparam int GcWarmRst = 2;
	localparam int GcLinkOff = 3;
	localparam logic [6:0] GcReset = 7'h02;

	localparam int GsReadyPri = 8;
	localparam int GsReadySec = 9;

	typedef struct packed {
		logic rst;
		logic wr_base;
		logic wr_lvi;
		logic wr_sts;
		logic wr_ctl;
	} chan_cmd_t;

	typedef struct packed {
		logic [31:0] base;
		idx_t        civ;
		idx_t        lvi;
		idx_t        piv;
		logic [4:0]  sts;
		logic [4:0]  ctl;
		logic        irq;
		logic        irq_next;
	} chan_view_t;

	function automatic logic chan_irq(input logic [4:0] sts, input logic [4:0] ctl);
		return (sts[4] & ctl[3]) | (sts[3] & ctl[4]) | (sts[2] & ctl[2]);
	endfunction

endpackage

// ----- rtl/mbmr_chan.sv -----
`timescale 1ns / 1ps

module mbmr_chan (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   update,
	input  mbmr_pkg::chan_cmd_t    cmd,
	input  logic [31:0]            wdata,
	output mbmr_pkg::chan_view_t   view
);
	import mbmr_pkg::*;

	logic [31:0] base_q, base_n;
	idx_t        civ_q, civ_n;
	idx_t        lvi_q, lvi_n;
	idx_t        piv_q, piv_n;
	logic [4:0]  sts_q, sts_n;
	logic [4:0]  ctl_q, ctl_n;

	always_comb begin
		base_n = base_q;
		civ_n  = civ_q;
		lvi_n  = lvi_q;
		piv_n  = piv_q;
		sts_n  = sts_q;
		ctl_n  = ctl_q;
		if (cmd.rst) begin
			base_n = '0;
			civ_n  = '0;
			lvi_n  = '0;
			piv_n  = '0;
			sts_n  = StReset;
			ctl_n  = ctl_q & CtIrqEn;
		end else if (cmd.wr_base) begin
			base_n = {wdata[31:2], 2'b00};
		end else if (cmd.wr_lvi) begin
			lvi_n = wdata[IndexBits-1:0];
		end else if (cmd.wr_sts) begin
			sts_n = sts_q & ~(wdata[4:0] & StClrMask);
		end else if (cmd.wr_ctl) begin
			ctl_n = wdata[4:0];
			if (wdata[CtRun]) begin
				sts_n[StHalt] = 1'b0;
				civ_n = piv_q;
				piv_n = piv_q + idx_t'(1);
			end else begin
				sts_n[StHalt] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			civ_q  <= '0;
			lvi_q  <= '0;
			piv_q  <= '0;
			sts_q  <= StReset;
			ctl_q  <= '0;
		end else if (update) begin
			base_q <= base_n;
			civ_q  <= civ_n;
			lvi_q  <= lvi_n;
			piv_q  <= piv_n;
			sts_q  <= sts_n;
			ctl_q  <= ctl_n;
		end
	end

	always_comb begin
		view.base     = base_q;
		view.civ      = civ_q;
		view.lvi      = lvi_q;
		view.piv      = piv_q;
		view.sts      = sts_q;
		view.ctl      = ctl_q;
		view.irq      = chan_irq(sts_q, ctl_q);
		view.irq_next = chan_irq(sts_n, ctl_n);
	end

endmodule

// ----- rtl/modem_bus_master_register_block_unit.sv -----
// Flow: an accepted request loads the input register; the result register is
// loaded from it when the output is free. Throughput: one access per cycle while
// the output does not stall; decode and register update sit between the input
// register and the result register. Reset: asynchronous, active low; control and
// state registers reset at once (channels halted, cold reset bit set), no clearing pass; data registers have no reset.
`timescale 1ns / 1ps

`include "modem_bus_master_register_block_unit_macros.svh"

module modem_bus_master_register_block_unit #(
	parameter int CHANNEL_COUNT = mbmr_pkg::ChannelCount
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [6:0]  address,
	input  logic [1:0]  access_size,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic        irq_level
);
	import mbmr_pkg::*;

	logic        codec_slot_q;
	logic        valid_s1;
	logic        mode_s1;
	logic [6:0]  address_s1;
	logic [1:0]  size_s1;
	logic [31:0] wdata_s1;
	logic        out_valid_q;
	logic [31:0] read_data_q;
	logic        irq_level_q;
	logic [6:0]  gc_q, gc_n;
	logic        sem_q, sem_n;

	logic        advance;
	logic        is_wr, in_chan;
	logic [3:0]  off;
	logic        base_hit, lvi_hit, sts_hit, ctl_hit;
	logic        gc_wr, link_rst, sem_rd;
	logic [31:0] rd_raw, rd_mask;
	logic [CHANNEL_COUNT-1:0] irq_cur, irq_nxt;

	chan_cmd_t  cmd   [CHANNEL_COUNT];
	chan_view_t views [CHANNEL_COUNT];
	chan_view_t v;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_slot_q <= 1'b0;
		end else if (cfg_we) begin
			codec_slot_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1    <= mode;
			address_s1 <= address;
			size_s1    <= access_size;
			wdata_s1   <= write_data;
		end
	end

	// decode
	assign is_wr    = (mode_s1 == ModeWrite);
	assign in_chan  = !address_s1[6] && !address_s1[5];
	assign off      = address_s1[3:0];
	assign base_hit = in_chan && off == OffBase && size_s1 == SizeWord;
	assign lvi_hit  = in_chan && off == OffLvi && size_s1 == SizeByte;
	assign sts_hit  = in_chan && off == OffSts && (size_s1 == SizeByte || size_s1 == SizeHalf);
	assign ctl_hit  = in_chan && off == OffCtl && size_s1 == SizeByte;
	assign gc_wr    = is_wr && address_s1 == AddrGlobCtl && size_s1 == SizeWord;
	assign link_rst = gc_wr && (wdata_s1[GcColdRst] || wdata_s1[GcWarmRst]);
	assign sem_rd   = advance && !is_wr && address_s1 == AddrSem && size_s1 == SizeByte;

	for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_chan
		logic sel;
		assign sel = is_wr && (address_s1[4] == 1'(g));
		always_comb begin
			cmd[g].rst     = link_rst || (sel && ctl_hit && wdata_s1[CtRst]);
			cmd[g].wr_base = sel && base_hit;
			cmd[g].wr_lvi  = sel && lvi_hit;
			cmd[g].wr_sts  = sel && sts_hit;
			cmd[g].wr_ctl  = sel && ctl_hit && !wdata_s1[CtRst];
		end
		mbmr_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.update (advance),
			.cmd    (cmd[g]),
			.wdata  (wdata_s1),
			.view   (views[g])
		);
		assign irq_cur[g] = views[g].irq;
		assign irq_nxt[g] = views[g].irq_next;
	end

	// global control: warm reset self-clears
	always_comb begin
		gc_n = gc_q;
		if (gc_wr) begin
			gc_n = {wdata_s1[6:3], 1'b0, wdata_s1[1:0]};
		end
		sem_n = sem_q;
		if (link_rst) begin
			sem_n = 1'b0;
		end else if (sem_rd) begin
			sem_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gc_q  <= GcReset;
			sem_q <= 1'b0;
		end else if (advance) begin
			gc_q  <= gc_n;
			sem_q <= sem_n;
		end
	end

	// read mux
	assign v = views[address_s1[4]];

	always_comb begin
		rd_raw = '1;
		if (in_chan) begin
			unique case (off)
				OffBase: if (size_s1 == SizeWord) rd_raw = v.base;
				OffCiv: begin
					if (size_s1 == SizeByte) begin
						rd_raw = 32'(v.civ);
					end else if (size_s1 == SizeWord) begin
						rd_raw = (32'(v.sts) << 16) | (32'(v.lvi) << 8) | 32'(v.civ);
					end
				end
				OffLvi:  if (size_s1 == SizeByte) rd_raw = 32'(v.lvi);
				OffSts:  if (size_s1 == SizeByte || size_s1 == SizeHalf) rd_raw = 32'(v.sts);
				OffPicb: if (size_s1 == SizeHalf) rd_raw = '0;
				OffPiv:  if (size_s1 == SizeByte) rd_raw = 32'(v.piv);
				OffCtl:  if (size_s1 == SizeByte) rd_raw = 32'(v.ctl);
				default: rd_raw = '1;
			endcase
		end else if (address_s1 == AddrGlobCtl && size_s1 == SizeWord) begin
			rd_raw = 32'(gc_q);
		end else if (address_s1 == AddrGlobSts && size_s1 == SizeWord) begin
			rd_raw = 32'({irq_cur, 1'b0});
			if (!gc_q[GcLinkOff]) begin
				rd_raw[GsReadyPri] = !codec_slot_q;
				rd_raw[GsReadySec] = codec_slot_q;
			end
		end else if (address_s1 == AddrSem && size_s1 == SizeByte) begin
			rd_raw = 32'(sem_q);
		end
	end

	always_comb begin
		unique case (size_s1)
			SizeByte: rd_mask = 32'h0000_00ff;
			SizeHalf: rd_mask = 32'h0000_ffff;
			default:  rd_mask = 32'hffff_ffff;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= is_wr ? '0 : (rd_raw & rd_mask);
			irq_level_q <= |irq_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign irq_level = irq_level_q;

	`MBMR_ASSERT_NEXT(a_wr_reads_zero, clk, arst_n, advance && is_wr, out_valid_q && read_data_q == '0)
	`MBMR_ASSERT_IMP(a_irq_tracks_state, clk, arst_n, out_valid_q, irq_level_q == |irq_cur)
	`MBMR_ASSERT_NEXT(a_sem_taken, clk, arst_n, sem_rd, sem_q)
	`MBMR_ASSERT_NEXT(a_link_rst_halts, clk, arst_n, advance && link_rst, views[0].sts[StHalt] && !gc_q[GcWarmRst] && !sem_q)

endmodule

// ----- tb/sv/tb_modem_bus_master_register_block_unit.sv -----
`timescale 1ns / 1ps

module tb_modem_bus_master_register_block_unit;
	import mbmr_pkg::*;

	localparam logic [1:0]  SizeNone      = 2'd3;
	localparam logic [15:0] GsClrMask     = 16'h8c07;
	localparam logic [6:0]  GcValid       = 7'h7f;
	localparam logic [6:0]  ChanWindow    = 7'h20;
	localparam logic [6:0]  ChanStride    = 7'h10;
	localparam int          WatchdogLimit = 1000;

	typedef struct {
		logic        mode;
		logic [6:0]  address;
		logic [1:0]  access_size;
		logic [31:0] write_data;
		int          gap;
	} bus_access_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_level;
	} bus_reply_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_we      = 1'b0;
	logic        cfg_wdata   = 1'b0;
	logic        in_valid    = 1'b0;
	logic        mode        = 1'b0;
	logic [6:0]  address     = '0;
	logic [1:0]  access_size = '0;
	logic [31:0] write_data  = '0;
	logic        out_ready   = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [31:0] read_data;
	logic        irq_level;

	// predicted register file
	logic [31:0] dma_base [ChannelCount];
	idx_t        civ      [ChannelCount];
	idx_t        lvi      [ChannelCount];
	idx_t        piv      [ChannelCount];
	logic [4:0]  chan_sts [ChannelCount];
	logic [4:0]  chan_ctl [ChannelCount];
	logic [6:0]  glob_ctl;
	logic [15:0] glob_sts;
	logic        sem_taken;
	logic        codec_slot_sel;

	bus_access_t access_queue [$];
	bus_reply_t  replies_due [$];
	bus_access_t staged;
	bus_reply_t  reply_head;
	logic        holding     = 1'b0;
	int          gap_left    = 0;
	int          hold_left   = 0;
	int          queued_total = 0;
	int          results_seen = 0;
	int          fault_count  = 0;
	int          idle_cycles  = 0;

	modem_bus_master_register_block_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.address    (address),
		.access_size(access_size),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.irq_level  (irq_level)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic channel_event(input int ch);
		return (chan_sts[ch][4] & chan_ctl[ch][3]) | (chan_sts[ch][3] & chan_ctl[ch][4]) |
			(chan_sts[ch][2] & chan_ctl[ch][2]);
	endfunction

	// global status bits 1 and 2 mirror the channel interrupts
	function automatic logic update_irq();
		logic level;
		level = 1'b0;
		for (int ch = 0; ch < ChannelCount; ch++) begin
			glob_sts[ch + 1] = channel_event(ch);
			level = level | channel_event(ch);
		end
		return level;
	endfunction

	function automatic void clear_channel(input int ch);
		dma_base[ch] = '0;
		civ[ch] = '0;
		lvi[ch] = '0;
		piv[ch] = '0;
		chan_sts[ch] = StReset;
		chan_ctl[ch] = chan_ctl[ch] & CtIrqEn;
		glob_sts[ch + 1] = 1'b0;
	endfunction

	function automatic void link_reset();
		for (int ch = 0; ch < ChannelCount; ch++)
			clear_channel(ch);
		sem_taken = 1'b0;
		glob_sts = glob_sts & ~GsClrMask;
		void'(update_irq());
	endfunction

	function automatic void reset_registers();
		for (int ch = 0; ch < ChannelCount; ch++)
			chan_ctl[ch] = '0;
		codec_slot_sel = 1'b0;
		glob_ctl = GcReset;
		glob_sts = '0;
		link_reset();
	endfunction

	function automatic logic [31:0] read_register(input logic [6:0] addr, input logic [1:0] sz);
		int ch;
		logic [31:0] v;
		v = '1;
		ch = int'(addr[4]);
		if (addr < ChanWindow) begin
			case (addr[3:0])
			OffBase: if (sz == SizeWord) v = dma_base[ch];
			OffCiv: begin
				if (sz == SizeByte)
					v = 32'(civ[ch]);
				else if (sz == SizeWord)
					v = {11'b0, chan_sts[ch], 3'b0, lvi[ch], 3'b0, civ[ch]};
			end
			OffLvi: if (sz == SizeByte) v = 32'(lvi[ch]);
			OffSts: if (sz == SizeByte || sz == SizeHalf) v = 32'(chan_sts[ch]);
			OffPicb: if (sz == SizeHalf) v = '0;
			OffPiv: if (sz == SizeByte) v = 32'(piv[ch]);
			OffCtl: if (sz == SizeByte) v = 32'(chan_ctl[ch]);
			default: ;
			endcase
		end else if (addr == AddrGlobCtl && sz == SizeWord) begin
			v = 32'(glob_ctl);
		end else if (addr == AddrGlobSts && sz == SizeWord) begin
			v = 32'(glob_sts);
			if (!glob_ctl[GcLinkOff])
				v[codec_slot_sel ? GsReadySec : GsReadyPri] = 1'b1;
		end else if (addr == AddrSem && sz == SizeByte) begin
			v = 32'(sem_taken);
			sem_taken = 1'b1;
		end
		return v;
	endfunction

	function automatic void write_register(input logic [6:0] addr, input logic [1:0] sz,
			input logic [31:0] val);
		int ch;
		logic [4:0] c;
		logic [6:0] g;
		ch = int'(addr[4]);
		if (addr < ChanWindow) begin
			case (addr[3:0])
			OffBase: if (sz == SizeWord) dma_base[ch] = {val[31:2], 2'b00};
			OffLvi: if (sz == SizeByte) lvi[ch] = val[4:0];
			OffSts: begin
				if (sz == SizeByte || sz == SizeHalf)
					chan_sts[ch] = chan_sts[ch] & ~(val[4:0] & StClrMask);
			end
			OffCtl: begin
				if (sz == SizeByte) begin
					c = val[4:0];
					if (c[CtRst]) begin
						clear_channel(ch);
					end else begin
						chan_ctl[ch] = c;
						if (c[CtRun]) begin
							chan_sts[ch][StHalt] = 1'b0;
							civ[ch] = piv[ch];
							piv[ch] = piv[ch] + 1'b1;
						end else begin
							chan_sts[ch][StHalt] = 1'b1;
						end
					end
				end
			end
			default: ;
			endcase
		end else if (addr == AddrGlobCtl && sz == SizeWord) begin
			g = val[6:0] & GcValid;
			if (g[GcColdRst] || g[GcWarmRst])
				link_reset();
			glob_ctl = g;
			glob_ctl[GcWarmRst] = 1'b0;
		end else if (addr == AddrGlobSts && sz == SizeWord) begin
			glob_sts = glob_sts & ~(val[15:0] & GsClrMask);
		end
	endfunction

	function automatic bus_reply_t bus_master_access(input logic md, input logic [6:0] addr,
			input logic [1:0] sz, input logic [31:0] val);
		bus_reply_t r;
		r.read_data = '0;
		if (md == ModeRead) begin
			r.read_data = read_register(addr, sz);
			if (sz == SizeByte)
				r.read_data[31:8] = '0;
			else if (sz == SizeHalf)
				r.read_data[31:16] = '0;
		end else begin
			write_register(addr, sz, val);
		end
		r.irq_level = update_irq();
		return r;
	endfunction

	// every third stretch of 100 items goes back to back
	function automatic void queue_access(input logic md, input logic [6:0] addr,
			input logic [1:0] sz, input logic [31:0] val);
		bus_access_t a;
		a.mode = md;
		a.address = addr;
		a.access_size = sz;
		a.write_data = val;
		a.gap = ((queued_total / 100) % 3 == 2) ? 0 : $urandom_range(0, 19);
		queued_total++;
		access_queue.push_back(a);
	endfunction

	function automatic void queue_random_access();
		logic md;
		logic [6:0] base;
		logic [31:0] val;
		int pick;
		md = 1'($urandom_range(0, 1));
		val = $urandom;
		base = $urandom_range(0, 1) ? ChanStride : 7'h00;
		pick = $urandom_range(0, 19);
		case (pick)
		0, 1: queue_access(md, base + OffBase, SizeWord, val);
		2: queue_access(ModeRead, base + OffCiv, SizeWord, val);
		3: queue_access(md, base + OffCiv, SizeByte, val);
		4, 5: queue_access(md, base + OffLvi, SizeByte, val);
		6: queue_access(md, base + OffSts, SizeByte, val);
		7: queue_access(md, base + OffSts, SizeHalf, val);
		8: queue_access(md, base + OffPicb, SizeHalf, val);
		9: queue_access(md, base + OffPiv, SizeByte, val);
		10, 11, 12: begin
			val[CtRst] = ($urandom_range(0, 9) == 0);
			queue_access(md, base + OffCtl, SizeByte, val);
		end
		13: begin
			val[GcColdRst] = ($urandom_range(0, 11) == 0);
			val[GcWarmRst] = ($urandom_range(0, 11) == 0);
			queue_access(md, AddrGlobCtl, SizeWord, val);
		end
		14: queue_access(md, AddrGlobSts, SizeWord, val);
		15: queue_access(md, AddrSem, SizeByte, val);
		default: queue_access(md, 7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)), val);
		endcase
	endfunction

	task automatic set_codec_slot(input logic slot);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= slot;
		@(posedge clk);
		cfg_we <= 1'b0;
		codec_slot_sel = slot;
	endtask

	task automatic wait_idle();
		while (access_queue.size() != 0 || holding || in_valid || replies_due.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			holding = 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready)
				replies_due.push_back(bus_master_access(mode, address, access_size, write_data));
			if (!(in_valid && !in_ready)) begin
				if (!holding && access_queue.size() != 0) begin
					staged = access_queue.pop_front();
					holding = 1'b1;
					gap_left = staged.gap;
				end
				if (holding && gap_left == 0) begin
					in_valid <= 1'b1;
					mode <= staged.mode;
					address <= staged.address;
					access_size <= staged.access_size;
					write_data <= staged.write_data;
					holding = 1'b0;
				end else begin
					in_valid <= 1'b0;
					if (holding)
						gap_left--;
				end
			end
		end
	end

	// reply side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: transfer with none due, read_data %h irq_level %b",
						$time, read_data, irq_level);
					fault_count++;
				end else begin
					reply_head = replies_due.pop_front();
					if (read_data !== reply_head.read_data) begin
						$display("%0t: read_data expected %h actual %h",
							$time, reply_head.read_data, read_data);
						fault_count++;
					end
					if (irq_level !== reply_head.irq_level) begin
						$display("%0t: irq_level expected %b actual %b",
							$time, reply_head.irq_level, irq_level);
						fault_count++;
					end
				end
				hold_left = ((results_seen / 128) % 3 == 1) ? 0 : $urandom_range(0, 19);
				results_seen++;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		reset_registers();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		set_codec_slot(1'b0);

		queue_access(ModeRead, 7'(OffBase), SizeWord, '0);
		queue_access(ModeRead, 7'(OffCiv), SizeWord, '0);
		queue_access(ModeRead, 7'(OffSts), SizeHalf, '0);
		queue_access(ModeRead, 7'(OffPicb), SizeHalf, '0);
		queue_access(ModeRead, AddrGlobCtl, SizeWord, '0);
		queue_access(ModeRead, AddrGlobSts, SizeWord, '0);
		queue_access(ModeRead, AddrSem, SizeByte, '0);
		queue_access(ModeRead, AddrSem, SizeByte, '0);
		queue_access(ModeWrite, 7'(OffBase), SizeWord, '1);
		queue_access(ModeWrite, ChanStride + OffLvi, SizeByte, '1);
		queue_access(ModeWrite, 7'(OffCtl), SizeByte, 32'h1d);
		queue_access(ModeRead, 7'(OffCiv), SizeWord, '0);
		queue_access(ModeRead, 7'(OffPiv), SizeByte, '0);
		queue_access(ModeWrite, 7'(OffSts), SizeByte, '1);
		queue_access(ModeWrite, 7'(OffCtl), SizeByte, 32'h02);
		queue_access(ModeRead, 7'(OffCtl), SizeByte, '0);
		queue_access(ModeWrite, AddrGlobCtl, SizeWord, 32'h7f);
		queue_access(ModeRead, AddrGlobCtl, SizeWord, '0);
		queue_access(ModeWrite, AddrGlobCtl, SizeWord, 32'h08);
		queue_access(ModeRead, AddrGlobSts, SizeWord, '0);
		queue_access(ModeWrite, AddrGlobSts, SizeWord, '1);
		queue_access(ModeRead, 7'(OffBase), SizeByte, '0);
		queue_access(ModeRead, 7'h7f, SizeNone, '0);
		queue_access(ModeWrite, 7'h60, SizeNone, '1);
		queue_access(ModeRead, ChanStride + OffCtl, SizeByte, '0);
		wait_idle();

		set_codec_slot(1'b1);
		repeat (700) queue_random_access();
		wait_idle();

		set_codec_slot(1'b0);
		repeat (700) queue_random_access();
		wait_idle();

		set_codec_slot(1'b1);
		repeat (600) queue_random_access();
		wait_idle();

		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
